// ===== src/rmvr_pkg.sv =====
package rmvr_pkg;

    // Fixed field widths and fixed point format
    localparam int SAMPLE_W  = 16;
    localparam int FRAC_BITS = 16;
    localparam int COUNT_W   = 32;
    localparam int MEAN_W    = 32;
    localparam int VAR_W     = 48;
    localparam int STD_W     = 32;
    localparam int SIGMA_W   = 8;

    // Internal datapath widths
    localparam int DIFF_W    = 33;                  // |x - mean|
    localparam int MUL_A_W   = 48;
    localparam int MUL_B_W   = 33;
    localparam int PROD_W    = 66;                  // d*d
    localparam int DIV_N_W   = PROD_W - FRAC_BITS;  // widest dividend
    localparam int DIV_D_W   = COUNT_W + 1;         // n+1
    localparam int ROOT_IN_W = VAR_W + FRAC_BITS;

    localparam logic [VAR_W-1:0]   VAR_ONE   = VAR_W'(1) << FRAC_BITS;
    localparam logic [VAR_W-1:0]   VAR_MAX   = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Item modes
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_CLEAR  = 1'b1;

    // Register indexes
    localparam logic REG_REJECT_ENABLE = 1'b0;
    localparam logic REG_REJECT_SIGMA  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_SQR,
        S_REJ_GO,
        S_REJ,
        S_DIVQ_GO,
        S_DIVQ,
        S_DIVV_GO,
        S_DIVV,
        S_DIVT_GO,
        S_DIVT,
        S_UPDATE,
        S_ROOT_GO,
        S_ROOT,
        S_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic take;
        logic clear;
        logic mul_sq;
        logic mul_rej;
        logic cap_dd;
        logic div_q;
        logic div_v;
        logic div_t;
        logic cap_q;
        logic cap_c;
        logic cap_t;
        logic update;
        logic sqrt_go;
        logic cap_std;
        logic std_zero;
        logic emit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_fire;
        logic is_clear;
        logic need_rej;
        logic rej_hit;
        logic n_zero;
        logic cnt_ge2;
        logic mul_done;
        logic div_done;
        logic sqrt_done;
        logic out_free;
    } sts_t;

endpackage

// ===== src/rmvr_in_if.sv =====
interface rmvr_in_if;
    logic                              valid;
    logic                              ready;
    logic                              mode;
    logic signed [rmvr_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, mode, sample, input ready);
    modport sink   (input valid, mode, sample, output ready);
endinterface

// ===== src/rmvr_out_if.sv =====
interface rmvr_out_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 accepted;
    logic        [rmvr_pkg::COUNT_W-1:0]  count;
    logic signed [rmvr_pkg::MEAN_W-1:0]   mean;
    logic        [rmvr_pkg::VAR_W-1:0]    variance;
    logic        [rmvr_pkg::STD_W-1:0]    std_dev;
    logic signed [rmvr_pkg::SAMPLE_W-1:0] minimum;
    logic signed [rmvr_pkg::SAMPLE_W-1:0] maximum;

    modport source (output valid, accepted, count, mean, variance, std_dev, minimum, maximum,
                    input ready);
    modport sink   (input valid, accepted, count, mean, variance, std_dev, minimum, maximum,
                    output ready);
endinterface

// ===== src/rmvr_mul.sv =====
module rmvr_mul (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [rmvr_pkg::MUL_A_W-1:0]   a,
    input  logic [rmvr_pkg::MUL_B_W-1:0]   b,
    output logic [rmvr_pkg::PROD_W-1:0]    prod,
    output logic                           done
);
    localparam int N     = rmvr_pkg::MUL_B_W;
    localparam int CNT_W = $clog2(N);

    logic                          busy_reg;
    logic                          done_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [rmvr_pkg::PROD_W-1:0]   acc_reg;
    logic [rmvr_pkg::PROD_W-1:0]   a_reg;
    logic [N-1:0]                  b_reg;

    // Control: one multiplier bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(N - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift-add datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= rmvr_pkg::PROD_W'(a);
            b_reg   <= b;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

    assign prod = acc_reg;
    assign done = done_reg;
endmodule

// ===== src/rmvr_div.sv =====
module rmvr_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [rmvr_pkg::DIV_N_W-1:0]   dividend,
    input  logic [rmvr_pkg::DIV_D_W-1:0]   divisor,
    output logic [rmvr_pkg::DIV_N_W-1:0]   quot,
    output logic                           done
);
    localparam int N     = rmvr_pkg::DIV_N_W;
    localparam int D     = rmvr_pkg::DIV_D_W;
    localparam int CNT_W = $clog2(N);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [D-1:0]     rem_reg;
    logic [N-1:0]     quo_reg;
    logic [D-1:0]     dvs_reg;
    logic [D:0]       partial;
    logic             fits;

    // Restoring step: bring down one dividend bit
    assign partial = {rem_reg, quo_reg[N-1]};
    assign fits    = partial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(N - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? D'(partial - {1'b0, dvs_reg}) : D'(partial);
            quo_reg <= {quo_reg[N-2:0], fits};
        end
    end

    assign quot = quo_reg;
    assign done = done_reg;
endmodule

// ===== src/rmvr_sqrt.sv =====
module rmvr_sqrt (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [rmvr_pkg::ROOT_IN_W-1:0]   radicand,
    output logic [rmvr_pkg::STD_W-1:0]       root,
    output logic                             done
);
    localparam int R     = rmvr_pkg::STD_W;
    localparam int X     = rmvr_pkg::ROOT_IN_W;
    localparam int REM_W = R + 2;
    localparam int CNT_W = $clog2(R);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [R-1:0]       root_reg;
    logic [X-1:0]       x_reg;
    logic [REM_W+1:0]   shifted;
    logic [REM_W+1:0]   trial;
    logic               fits;

    // One result bit per cycle, two radicand bits brought down
    assign shifted = {rem_reg, x_reg[X-1:X-2]};
    assign trial   = (REM_W + 2)'({root_reg, 2'b01});
    assign fits    = shifted >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(R - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            root_reg <= '0;
            x_reg    <= radicand;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? REM_W'(shifted - trial) : REM_W'(shifted);
            root_reg <= {root_reg[R-2:0], fits};
            x_reg    <= x_reg << 2;
        end
    end

    assign root = root_reg;
    assign done = done_reg;
endmodule

// ===== src/rmvr_ctrl.sv =====
module rmvr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  rmvr_pkg::sts_t   sts,
    output rmvr_pkg::cmd_t   cmd
);
    rmvr_pkg::state_t state_reg;
    rmvr_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rmvr_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rmvr_pkg::S_IDLE:
                if (sts.in_fire) state_next = rmvr_pkg::S_DECIDE;
            rmvr_pkg::S_DECIDE:
                state_next = sts.is_clear ? rmvr_pkg::S_EMIT : rmvr_pkg::S_SQR;
            rmvr_pkg::S_SQR:
                if (sts.mul_done)
                    state_next = sts.need_rej ? rmvr_pkg::S_REJ_GO : rmvr_pkg::S_DIVQ_GO;
            rmvr_pkg::S_REJ_GO:
                state_next = rmvr_pkg::S_REJ;
            rmvr_pkg::S_REJ:
                if (sts.mul_done)
                    state_next = sts.rej_hit ? rmvr_pkg::S_EMIT : rmvr_pkg::S_DIVQ_GO;
            rmvr_pkg::S_DIVQ_GO:
                state_next = rmvr_pkg::S_DIVQ;
            rmvr_pkg::S_DIVQ:
                if (sts.div_done)
                    state_next = sts.n_zero ? rmvr_pkg::S_DIVT_GO : rmvr_pkg::S_DIVV_GO;
            rmvr_pkg::S_DIVV_GO:
                state_next = rmvr_pkg::S_DIVV;
            rmvr_pkg::S_DIVV:
                if (sts.div_done) state_next = rmvr_pkg::S_DIVT_GO;
            rmvr_pkg::S_DIVT_GO:
                state_next = rmvr_pkg::S_DIVT;
            rmvr_pkg::S_DIVT:
                if (sts.div_done) state_next = rmvr_pkg::S_UPDATE;
            rmvr_pkg::S_UPDATE:
                state_next = rmvr_pkg::S_ROOT_GO;
            rmvr_pkg::S_ROOT_GO:
                state_next = sts.cnt_ge2 ? rmvr_pkg::S_ROOT : rmvr_pkg::S_EMIT;
            rmvr_pkg::S_ROOT:
                if (sts.sqrt_done) state_next = rmvr_pkg::S_EMIT;
            rmvr_pkg::S_EMIT:
                if (sts.out_free) state_next = rmvr_pkg::S_IDLE;
            default:
                state_next = rmvr_pkg::S_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            rmvr_pkg::S_IDLE:    cmd.take     = 1'b1;
            rmvr_pkg::S_DECIDE:
            begin
                cmd.clear  = sts.is_clear;
                cmd.mul_sq = !sts.is_clear;
            end
            rmvr_pkg::S_SQR:     cmd.cap_dd   = sts.mul_done;
            rmvr_pkg::S_REJ_GO:  cmd.mul_rej  = 1'b1;
            rmvr_pkg::S_DIVQ_GO: cmd.div_q    = 1'b1;
            rmvr_pkg::S_DIVQ:    cmd.cap_q    = sts.div_done;
            rmvr_pkg::S_DIVV_GO: cmd.div_v    = 1'b1;
            rmvr_pkg::S_DIVV:    cmd.cap_c    = sts.div_done;
            rmvr_pkg::S_DIVT_GO: cmd.div_t    = 1'b1;
            rmvr_pkg::S_DIVT:    cmd.cap_t    = sts.div_done;
            rmvr_pkg::S_UPDATE:  cmd.update   = 1'b1;
            rmvr_pkg::S_ROOT_GO:
            begin
                cmd.sqrt_go  = sts.cnt_ge2;
                cmd.std_zero = !sts.cnt_ge2;
            end
            rmvr_pkg::S_ROOT:    cmd.cap_std  = sts.sqrt_done;
            rmvr_pkg::S_EMIT:    cmd.emit     = sts.out_free;
            default:             cmd          = '0;
        endcase
    end

    // No two of the shared units are started in the same cycle
    a_one_start: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.mul_sq, cmd.mul_rej, cmd.div_q, cmd.div_v, cmd.div_t, cmd.sqrt_go}))
        else $error("two units started together");

    // A unit finishes only while the controller waits on it
    a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
        sts.mul_done |-> (state_reg == rmvr_pkg::S_SQR || state_reg == rmvr_pkg::S_REJ))
        else $error("multiplier done outside its wait state");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> (state_reg == rmvr_pkg::S_DIVQ || state_reg == rmvr_pkg::S_DIVV
                          || state_reg == rmvr_pkg::S_DIVT))
        else $error("divider done outside its wait state");

    a_sqrt_done: assert property (@(posedge clk) disable iff (!rst_n)
        sts.sqrt_done |-> state_reg == rmvr_pkg::S_ROOT)
        else $error("square root done outside its wait state");

    // After a transfer in, the next cycle decides
    a_decide: assert property (@(posedge clk) disable iff (!rst_n)
        sts.in_fire |=> state_reg == rmvr_pkg::S_DECIDE)
        else $error("item taken without moving to decide");
endmodule

// ===== src/rmvr_datapath.sv =====
module rmvr_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rmvr_pkg::cmd_t                  cmd,
    output rmvr_pkg::sts_t                  sts,
    rmvr_in_if.sink                         item,
    rmvr_out_if.source                      result,
    input  logic                            wr_en,
    input  logic                            wr_index,
    input  logic [rmvr_pkg::SIGMA_W-1:0]    wr_data
);
    localparam int SW = rmvr_pkg::SAMPLE_W;
    localparam int CW = rmvr_pkg::COUNT_W;
    localparam int MW = rmvr_pkg::MEAN_W;
    localparam int VW = rmvr_pkg::VAR_W;
    localparam int FB = rmvr_pkg::FRAC_BITS;

    // Configuration
    logic                            en_reg;
    logic [rmvr_pkg::SIGMA_W-1:0]    sigma_reg;

    // Statistics
    logic [CW-1:0]           count_reg;
    logic signed [MW-1:0]    mean_reg;
    logic [VW-1:0]           var_reg;
    logic signed [SW-1:0]    min_reg;
    logic signed [SW-1:0]    max_reg;
    logic [rmvr_pkg::STD_W-1:0] std_reg;

    // Per-item working registers
    logic                    mode_reg;
    logic signed [SW-1:0]    smp_reg;
    logic                    neg_reg;
    logic [rmvr_pkg::DIFF_W-1:0] ad_reg;
    logic [rmvr_pkg::PROD_W-1:0] dd_reg;
    logic [rmvr_pkg::DIFF_W-1:0] q_reg;
    logic [VW-1:0]           c_reg;
    logic [rmvr_pkg::DIV_N_W-1:0] t_reg;
    logic                    acc_reg;

    // Output register
    logic                    out_valid_reg;
    logic                    out_acc_reg;
    logic [CW-1:0]           out_count_reg;
    logic signed [MW-1:0]    out_mean_reg;
    logic [VW-1:0]           out_var_reg;
    logic [rmvr_pkg::STD_W-1:0] out_std_reg;
    logic signed [SW-1:0]    out_min_reg;
    logic signed [SW-1:0]    out_max_reg;

    logic                    in_fire;
    logic                    out_free;
    logic signed [MW-1:0]    x_val;
    logic signed [MW+1:0]    diff;
    logic [MW+1:0]           diff_abs;

    logic [2*rmvr_pkg::SIGMA_W-1:0] sigma_sq;
    logic                    mul_start;
    logic [rmvr_pkg::MUL_A_W-1:0] mul_a;
    logic [rmvr_pkg::MUL_B_W-1:0] mul_b;
    logic [rmvr_pkg::PROD_W-1:0]  prod;
    logic                    mul_done;

    logic                    div_start;
    logic [rmvr_pkg::DIV_N_W-1:0] div_n;
    logic [rmvr_pkg::DIV_D_W-1:0] div_d;
    logic [rmvr_pkg::DIV_N_W-1:0] quot;
    logic                    div_done;

    logic [rmvr_pkg::STD_W-1:0] root;
    logic                    sqrt_done;

    logic [rmvr_pkg::DIV_D_W-1:0] n_plus1;
    logic signed [MW+2:0]    mean_sum;
    logic signed [MW-1:0]    mean_next;
    logic [VW-1:0]           var_less;
    logic [rmvr_pkg::DIV_N_W:0] var_sum;
    logic [VW-1:0]           var_next;
    logic [79:0]             rej_lhs;
    logic [79:0]             rej_rhs;

    assign item.ready = cmd.take;
    assign in_fire    = item.valid & cmd.take;
    assign out_free   = !out_valid_reg || result.ready;

    // Difference of the scaled sample and the mean
    assign x_val    = MW'(item.sample) <<< FB;
    assign diff     = (MW + 2)'(x_val) - (MW + 2)'(mean_reg);
    assign diff_abs = diff[MW+1] ? (MW + 2)'(-diff) : diff;

    assign n_plus1  = rmvr_pkg::DIV_D_W'(count_reg) + 1'b1;

    // Shared unit operand selection
    assign sigma_sq  = sigma_reg * sigma_reg;
    assign mul_start = cmd.mul_sq | cmd.mul_rej;
    assign mul_a     = cmd.mul_rej ? var_reg : rmvr_pkg::MUL_A_W'(ad_reg);
    assign mul_b     = cmd.mul_rej ? rmvr_pkg::MUL_B_W'(sigma_sq) : ad_reg;

    assign div_start = cmd.div_q | cmd.div_v | cmd.div_t;
    always_comb
    begin
        div_n = rmvr_pkg::DIV_N_W'(ad_reg);
        div_d = n_plus1;
        if (cmd.div_v)
        begin
            div_n = rmvr_pkg::DIV_N_W'(var_reg) + rmvr_pkg::DIV_N_W'(count_reg) - 1'b1;
            div_d = rmvr_pkg::DIV_D_W'(count_reg);
        end
        else if (cmd.div_t)
        begin
            div_n = dd_reg[rmvr_pkg::PROD_W-1:FB];
        end
    end

    rmvr_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (prod),
        .done  (mul_done)
    );

    rmvr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .quot     (quot),
        .done     (div_done)
    );

    rmvr_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_go),
        .radicand ({var_reg, FB'(0)}),
        .root     (root),
        .done     (sqrt_done)
    );

    // Rejection: d*d * 2^8 > sigma^2 * variance * 2^FRAC_BITS
    assign rej_lhs = 80'({dd_reg, 8'b0});
    assign rej_rhs = 80'({prod[63:0], FB'(0)});

    // Mean update with saturation
    assign mean_sum = neg_reg ? (MW + 3)'(mean_reg) - (MW + 3)'(q_reg)
                              : (MW + 3)'(mean_reg) + (MW + 3)'(q_reg);
    always_comb
    begin
        if (mean_sum > $signed((MW + 3)'({1'b0, {(MW - 1){1'b1}}})))
            mean_next = {1'b0, {(MW - 1){1'b1}}};
        else if (mean_sum < -((MW + 3)'(1) <<< (MW - 1)))
            mean_next = {1'b1, {(MW - 1){1'b0}}};
        else
            mean_next = MW'(mean_sum);
    end

    // Variance update with saturation
    assign var_less = count_reg == '0 ? var_reg : var_reg - c_reg;
    assign var_sum  = (rmvr_pkg::DIV_N_W + 1)'(var_less) + (rmvr_pkg::DIV_N_W + 1)'(t_reg);
    assign var_next = var_sum > (rmvr_pkg::DIV_N_W + 1)'(rmvr_pkg::VAR_MAX)
                      ? rmvr_pkg::VAR_MAX : VW'(var_sum);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg    <= 1'b0;
            sigma_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                rmvr_pkg::REG_REJECT_ENABLE: en_reg    <= wr_data[0];
                rmvr_pkg::REG_REJECT_SIGMA:  sigma_reg <= wr_data;
                default:                     en_reg    <= en_reg;
            endcase
        end
    end

    // Statistics state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            mean_reg  <= '0;
            var_reg   <= '0;
            min_reg   <= '0;
            max_reg   <= '0;
            std_reg   <= '0;
            acc_reg   <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                acc_reg <= 1'b0;
            end
            if (cmd.clear)
            begin
                count_reg <= '0;
                mean_reg  <= '0;
                var_reg   <= '0;
                min_reg   <= '0;
                max_reg   <= '0;
                std_reg   <= '0;
            end
            if (cmd.update)
            begin
                acc_reg  <= 1'b1;
                mean_reg <= mean_next;
                var_reg  <= var_next;
                if (count_reg == '0)
                begin
                    min_reg <= smp_reg;
                    max_reg <= smp_reg;
                end
                else
                begin
                    if (smp_reg < min_reg) min_reg <= smp_reg;
                    if (smp_reg > max_reg) max_reg <= smp_reg;
                end
                if (count_reg != rmvr_pkg::COUNT_MAX)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.std_zero)
            begin
                std_reg <= '0;
            end
            if (cmd.cap_std)
            begin
                std_reg <= root;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg <= item.mode;
            smp_reg  <= item.sample;
            neg_reg  <= diff[MW+1];
            ad_reg   <= rmvr_pkg::DIFF_W'(diff_abs);
        end
        if (cmd.cap_dd) dd_reg <= prod;
        if (cmd.cap_q)  q_reg  <= rmvr_pkg::DIFF_W'(quot);
        if (cmd.cap_c)  c_reg  <= VW'(quot);
        if (cmd.cap_t)  t_reg  <= quot;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_acc_reg   <= acc_reg;
            out_count_reg <= count_reg;
            out_mean_reg  <= mean_reg;
            out_var_reg   <= var_reg;
            out_std_reg   <= std_reg;
            out_min_reg   <= min_reg;
            out_max_reg   <= max_reg;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.accepted = out_acc_reg;
    assign result.count    = out_count_reg;
    assign result.mean     = out_mean_reg;
    assign result.variance = out_var_reg;
    assign result.std_dev  = out_std_reg;
    assign result.minimum  = out_min_reg;
    assign result.maximum  = out_max_reg;

    // Status
    always_comb
    begin
        sts           = '0;
        sts.in_fire   = in_fire;
        sts.is_clear  = mode_reg == rmvr_pkg::MODE_CLEAR;
        sts.need_rej  = (count_reg >= CW'(2)) && en_reg && (var_reg >= rmvr_pkg::VAR_ONE);
        sts.rej_hit   = rej_lhs > rej_rhs;
        sts.n_zero    = count_reg == '0;
        sts.cnt_ge2   = count_reg >= CW'(2);
        sts.mul_done  = mul_done;
        sts.div_done  = div_done;
        sts.sqrt_done = sqrt_done;
        sts.out_free  = out_free;
    end

    // An emitted result of a sample that was taken counts at least one
    a_acc_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && acc_reg |=> out_count_reg != '0)
        else $error("accepted result with zero count");

    // Count and variance change only in response to a clear or an update
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.clear && !cmd.update |=> $stable(count_reg) && $stable(var_reg))
        else $error("statistics changed without command");

    // Minimum never above maximum once samples are in
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 |-> min_reg <= max_reg)
        else $error("minimum above maximum");
endmodule

// ===== src/running_mean_variance_with_rejection.sv =====
// Sequence: a clear item goes from decide to output load; a sample item runs through decide,
//   squaring, a rejection product when enabled, the divisions, update, square root and
//   output load on the bit-per-cycle units; a rejected sample goes straight to output load.
// Items: one item at a time; the next item transfers only after the result is loaded
//   into the output register, and that load waits while the output is not free.
// Reset: rst_n clears statistics, configuration and control; no clearing pass.
module running_mean_variance_with_rejection (
    input  logic                           clk,
    input  logic                           rst_n,
    rmvr_in_if.sink                        item,
    rmvr_out_if.source                     result,
    input  logic                           wr_en,
    input  logic                           wr_index,
    input  logic [rmvr_pkg::SIGMA_W-1:0]   wr_data
);
    rmvr_pkg::cmd_t cmd;
    rmvr_pkg::sts_t sts;

    rmvr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    rmvr_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .item     (item),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );
endmodule
